FILE: design/bda_pkg.sv
package bda_pkg;

  // Field and register widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_DELAY  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_PERIOD = 2'd2;

  // Register reset values in milliseconds
  localparam logic [CfgW-1:0] DEBOUNCE_RST      = 16'd20;
  localparam logic [CfgW-1:0] REPEAT_DELAY_RST  = 16'd500;
  localparam logic [CfgW-1:0] REPEAT_PERIOD_RST = 16'd100;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] repeat_delay_ms;
    logic [CfgW-1:0] repeat_period_ms;
  } cfg_t;

  // Per-button result of one update
  typedef struct packed {
    logic down;
    logic pressed;
    logic released;
  } lane_evt_t;

endpackage

FILE: design/button_debounce_autorepeat_core.sv
// Each accepted update goes to the input register, then to the result register.
// Throughput: one update per cycle while m_axis is ready; the input register
// holds one more update while a finished result waits on the output register.
// The state of each button is read and written in the same cycle by its own lane.
// Reset (rst_ni low, asynchronous): both stages empty, all button state zero,
// registers back to debounce 20, repeat delay 500, repeat period 100 ms.
module button_debounce_autorepeat_core #(
  parameter int unsigned BUTTON_COUNT = 5
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration write port
  input  logic                                    cfg_we_i,
  input  logic [bda_pkg::CfgIdxW-1:0]              cfg_idx_i,
  input  logic [bda_pkg::CfgW-1:0]                 cfg_data_i,
  // Update stream
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // raw_levels, now_ms, zero pad
  input  logic [((BUTTON_COUNT+32+7)/8)*8-1:0]     s_axis_tdata,
  // Result stream
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // down_mask, pressed_mask, released_mask, zero pad
  output logic [((3*BUTTON_COUNT+7)/8)*8-1:0]      m_axis_tdata
);
  import bda_pkg::*;

  cfg_t                     cfg;
  lane_evt_t                evt [BUTTON_COUNT];

  logic                     in_vld_q;
  logic [BUTTON_COUNT-1:0]  raw_q;
  logic [TimeW-1:0]         now_q;
  logic                     s_acc;
  logic                     adv;

  logic                     out_vld_q;
  logic [BUTTON_COUNT-1:0]  down_q, down_d;
  logic [BUTTON_COUNT-1:0]  pressed_q, pressed_d;
  logic [BUTTON_COUNT-1:0]  released_q, released_d;

  bda_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Handshake: the input stage moves on when the result register is free
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      raw_q <= s_axis_tdata[BUTTON_COUNT-1:0];
      now_q <= s_axis_tdata[BUTTON_COUNT+TimeW-1:BUTTON_COUNT];
    end
  end

  // One lane per button
  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
    bda_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .raw_i  (raw_q[g]),
      .now_i  (now_q),
      .cfg_i  (cfg),
      .evt_o  (evt[g])
    );
    assign down_d[g]     = evt[g].down;
    assign pressed_d[g]  = evt[g].pressed;
    assign released_d[g] = evt[g].released;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      down_q     <= down_d;
      pressed_q  <= pressed_d;
      released_q <= released_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[3*BUTTON_COUNT-1:0] = {released_q, pressed_q, down_q};
  end

`ifndef SYNTHESIS
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("result register empty after an update moved on");

  a_press_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((pressed_q & released_q) == '0))
    else $error("press and release on the same button");

  a_press_is_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((pressed_q & ~down_q) == '0))
    else $error("press reported on a button that is not down");

  a_release_is_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((released_q & down_q) == '0))
    else $error("release reported on a button that is down");
`endif

endmodule

FILE: design/bda_cfg_regs.sv
module bda_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [bda_pkg::CfgIdxW-1:0] idx_i,
  input  logic [bda_pkg::CfgW-1:0]    data_i,
  output bda_pkg::cfg_t              cfg_o
);
  import bda_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Register decode; unknown indexes leave everything as is
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        REG_DEBOUNCE:      cfg_d.debounce_ms      = data_i;
        REG_REPEAT_DELAY:  cfg_d.repeat_delay_ms  = data_i;
        REG_REPEAT_PERIOD: cfg_d.repeat_period_ms = data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms      <= DEBOUNCE_RST;
      cfg_q.repeat_delay_ms  <= REPEAT_DELAY_RST;
      cfg_q.repeat_period_ms <= REPEAT_PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/bda_lane.sv
module bda_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    raw_i,
  input  logic [bda_pkg::TimeW-1:0] now_i,
  input  bda_pkg::cfg_t           cfg_i,
  output bda_pkg::lane_evt_t      evt_o
);
  import bda_pkg::*;

  localparam int unsigned ExtW = TimeW - CfgW;

  logic             last_raw_q, last_raw_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] change_q, change_d;
  logic [TimeW-1:0] hold_q, hold_d;
  logic [TimeW-1:0] rep_q, rep_d;

  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] since_hold;
  logic [TimeW-1:0] since_rep;
  logic             pressed;
  logic             released;

  // Change time is refreshed first, so the debounce check sees the new value
  assign change_d     = (raw_i != last_raw_q) ? now_i : change_q;
  assign last_raw_d   = raw_i;
  assign since_change = now_i - change_d;
  assign since_hold   = now_i - hold_q;
  assign since_rep    = now_i - rep_q;

  // Debounce and auto repeat decision
  always_comb begin
    stable_d = stable_q;
    hold_d   = hold_q;
    rep_d    = rep_q;
    pressed  = 1'b0;
    released = 1'b0;
    if (raw_i != stable_q) begin
      if (since_change >= {{ExtW{1'b0}}, cfg_i.debounce_ms}) begin
        stable_d = raw_i;
        if (raw_i) begin
          pressed = 1'b1;
          hold_d  = now_i;
          rep_d   = now_i;
        end else begin
          released = 1'b1;
        end
      end
    end else if (stable_q) begin
      if (since_hold >= {{ExtW{1'b0}}, cfg_i.repeat_delay_ms} &&
          since_rep >= {{ExtW{1'b0}}, cfg_i.repeat_period_ms}) begin
        pressed = 1'b1;
        rep_d   = now_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      stable_q   <= 1'b0;
      change_q   <= '0;
      hold_q     <= '0;
      rep_q      <= '0;
    end else if (en_i) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      change_q   <= change_d;
      hold_q     <= hold_d;
      rep_q      <= rep_d;
    end
  end

  assign evt_o.down     = stable_d;
  assign evt_o.pressed  = pressed;
  assign evt_o.released = released;

endmodule

FILE: verif/button_debounce_autorepeat_core_test.sv
`timescale 1ns / 1ps

// Expected masks for one update result
typedef struct packed {
  logic [4:0] down;
  logic [4:0] pressed;
  logic [4:0] released;
} button_masks_t;

// Tracks per-button debounce and repeat state and holds the expected masks
class debounce_scoreboard;
  localparam int NumButtons = 5;

  logic [bda_pkg::CfgW-1:0]  debounce_ms;
  logic [bda_pkg::CfgW-1:0]  repeat_delay_ms;
  logic [bda_pkg::CfgW-1:0]  repeat_period_ms;
  logic [NumButtons-1:0]     seen_raw;
  logic [NumButtons-1:0]     stable_down;
  logic [bda_pkg::TimeW-1:0] edge_ms [NumButtons];
  logic [bda_pkg::TimeW-1:0] hold_ms [NumButtons];
  logic [bda_pkg::TimeW-1:0] repeat_ms [NumButtons];
  button_masks_t             expected_masks[$];
  int                        mismatch_count;

  function new();
    debounce_ms      = bda_pkg::DEBOUNCE_RST;
    repeat_delay_ms  = bda_pkg::REPEAT_DELAY_RST;
    repeat_period_ms = bda_pkg::REPEAT_PERIOD_RST;
    seen_raw         = '0;
    stable_down      = '0;
    for (int i = 0; i < NumButtons; i++) begin
      edge_ms[i]   = '0;
      hold_ms[i]   = '0;
      repeat_ms[i] = '0;
    end
    mismatch_count = 0;
  endfunction

  function void write_register(logic [bda_pkg::CfgIdxW-1:0] idx,
                               logic [bda_pkg::CfgW-1:0] value);
    case (idx)
      bda_pkg::REG_DEBOUNCE:      debounce_ms      = value;
      bda_pkg::REG_REPEAT_DELAY:  repeat_delay_ms  = value;
      bda_pkg::REG_REPEAT_PERIOD: repeat_period_ms = value;
      default: ;
    endcase
  endfunction

  // Advance every button by one update and queue the masks it produces
  function void note_update(logic [NumButtons-1:0] raw, logic [bda_pkg::TimeW-1:0] now);
    button_masks_t             masks;
    logic [bda_pkg::TimeW-1:0] since_edge;
    logic [bda_pkg::TimeW-1:0] since_hold;
    logic [bda_pkg::TimeW-1:0] since_repeat;
    masks = '0;
    for (int i = 0; i < NumButtons; i++) begin
      if (raw[i] != seen_raw[i]) begin
        seen_raw[i] = raw[i];
        edge_ms[i]  = now;
      end
      since_edge   = now - edge_ms[i];
      since_hold   = now - hold_ms[i];
      since_repeat = now - repeat_ms[i];
      if (raw[i] != stable_down[i]) begin
        // pending change: becomes stable once it has held long enough
        if (since_edge >= {16'b0, debounce_ms}) begin
          stable_down[i] = raw[i];
          if (raw[i]) begin
            masks.pressed[i] = 1'b1;
            hold_ms[i]       = now;
            repeat_ms[i]     = now;
          end else begin
            masks.released[i] = 1'b1;
          end
        end
      end else if (stable_down[i] && since_hold >= {16'b0, repeat_delay_ms} &&
                   since_repeat >= {16'b0, repeat_period_ms}) begin
        // auto repeat while held
        repeat_ms[i]     = now;
        masks.pressed[i] = 1'b1;
      end
    end
    masks.down = stable_down;
    expected_masks.push_back(masks);
  endfunction

  function void check_result(logic [15:0] data);
    button_masks_t want;
    if (expected_masks.size() == 0) begin
      $error("result transaction with no update pending: %h", data);
      mismatch_count++;
      return;
    end
    want = expected_masks.pop_front();
    if (data[4:0] != want.down) begin
      $error("down_mask: expected %h, actual %h", want.down, data[4:0]);
      mismatch_count++;
    end
    if (data[9:5] != want.pressed) begin
      $error("pressed_mask: expected %h, actual %h", want.pressed, data[9:5]);
      mismatch_count++;
    end
    if (data[14:10] != want.released) begin
      $error("released_mask: expected %h, actual %h", want.released, data[14:10]);
      mismatch_count++;
    end
  endfunction

  function int pending();
    return expected_masks.size();
  endfunction
endclass

module button_debounce_autorepeat_core_test;
  import bda_pkg::*;

  localparam int NumButtons = 5;
  localparam int StallLimit = 5000;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // raw_levels [4:0], now_ms [36:5], zero pad [39:37]
  logic [39:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // down_mask [4:0], pressed_mask [9:5], released_mask [14:10], zero pad [15]
  logic [15:0]        m_axis_tdata;

  debounce_scoreboard        sb = new();
  logic                      idle_en = 1'b1;
  logic [NumButtons-1:0]     held_target = '0;
  logic [TimeW-1:0]          clock_ms = '0;
  int                        stall_cycles = 0;

  button_debounce_autorepeat_core #(
    .BUTTON_COUNT(NumButtons)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Result side: random back-pressure and checking
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
    m_axis_tready <= !(idle_en && $urandom_range(99) < 23);
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("button_debounce_autorepeat_core verification failed");
        $finish;
      end
    end
  end

  // Send one update, idling at random before it
  task automatic send_update(input logic [NumButtons-1:0] raw, input logic [TimeW-1:0] now);
    while (idle_en && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b0, now, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_update(raw, now);
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_register(idx, value);
  endtask

  task automatic set_timing(input logic [CfgW-1:0] debounce, input logic [CfgW-1:0] delay,
                            input logic [CfgW-1:0] period);
    drain_results();
    write_register(REG_DEBOUNCE, debounce);
    write_register(REG_REPEAT_DELAY, delay);
    write_register(REG_REPEAT_PERIOD, period);
    // out-of-range index must leave the registers alone
    write_register(REG_UNUSED, CfgW'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Held buttons with bounce noise, time mostly creeping forward with
  // occasional big jumps and steps backwards
  task automatic run_random(input int count, input int step_max);
    int                    roll;
    logic [NumButtons-1:0] raw;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 8) held_target ^= NumButtons'(1 << $urandom_range(NumButtons - 1));
      roll = $urandom_range(99);
      if (roll < 4) raw = NumButtons'($urandom);
      else if (roll < 18) raw = held_target ^ NumButtons'($urandom);
      else raw = held_target;
      roll = $urandom_range(99);
      if (roll < 70) clock_ms += $urandom_range(step_max);
      else if (roll < 82) clock_ms += 0;
      else if (roll < 88) clock_ms += $urandom;
      else if (roll < 93) clock_ms -= $urandom_range(50, 1);
      else clock_ms += 4 * step_max;
      if (k == count / 2) drain_results();
      send_update(raw, clock_ms);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default timing, press, repeat, release, bounce, wrap
    send_update(5'h00, 32'd0);
    send_update(5'h1F, 32'd0);
    send_update(5'h1F, 32'd19);
    send_update(5'h1F, 32'd20);
    send_update(5'h1F, 32'd519);
    send_update(5'h1F, 32'd520);
    send_update(5'h1F, 32'd619);
    send_update(5'h1F, 32'd620);
    send_update(5'h15, 32'd700);
    send_update(5'h15, 32'd720);
    send_update(5'h1F, 32'd725);
    send_update(5'h15, 32'd730);
    send_update(5'h00, 32'hFFFF_FFFF);
    send_update(5'h00, 32'd19);
    send_update(5'h1F, 32'hFFFF_FFF0);
    send_update(5'h1F, 32'd4);
    send_update(5'h1F, 32'h8000_0000);

    clock_ms = $urandom;
    run_random(250, 40);

    // Zero timing: changes settle at once and held buttons repeat every update
    set_timing(16'd0, 16'd0, 16'd0);
    send_update(5'h1F, 32'd100);
    send_update(5'h1F, 32'd100);
    send_update(5'h00, 32'd100);
    send_update(5'h0A, 32'hFFFF_FFFF);
    run_random(150, 3);

    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    clock_ms = 32'hFFFF_0000;
    run_random(100, 30000);

    // Back-to-back stretch with no idling on either side
    set_timing(16'd3, 16'd30, 16'd7);
    idle_en = 1'b0;
    run_random(250, 10);
    idle_en = 1'b1;

    set_timing(CfgW'($urandom_range(200)), CfgW'($urandom_range(400)),
               CfgW'($urandom_range(100)));
    clock_ms = $urandom;
    run_random(300, 50);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("button_debounce_autorepeat_core verification clean");
    end else begin
      $display("button_debounce_autorepeat_core verification failed");
    end
    $finish;
  end

endmodule
